[rtl/asm_pkg.sv]
// Shared types, phase codes, mux codes and helper functions for the ADC scan
// median accumulator. No dependencies; imported by every other file.
package asm_pkg;

	// Scan shape
	localparam logic [3:0] Channels          = 4'd7;
	localparam logic [5:0] SamplesPerChannel = 6'd16;

	// Command codes
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_STOP  = 2'd1;
	localparam logic [1:0] CMD_CONV  = 2'd2;
	localparam logic [1:0] CMD_POLL  = 2'd3;

	// Phase codes
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_START  = 3'd1;
	localparam logic [2:0] PH_S1     = 3'd2;
	localparam logic [2:0] PH_S2     = 3'd3;
	localparam logic [2:0] PH_S3     = 3'd4;
	localparam logic [2:0] PH_GROUND = 3'd5;
	localparam logic [2:0] PH_NEXT   = 3'd6;
	localparam logic [2:0] PH_DONE   = 3'd7;

	// Mux codes
	localparam logic [3:0] MUX_GROUND  = 4'hF;
	localparam logic [3:0] MUX_BANDGAP = 4'hE;

	typedef struct packed {
		logic [1:0] command;
		logic [9:0] sample;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [3:0]  mux_code;
		logic        start_conversion;
		logic        sum_valid;
		logic [3:0]  sum_channel;
		logic [15:0] sum_value;
	} res_t;

	// Median of three samples
	function automatic logic [9:0] med3(input logic [9:0] a, input logic [9:0] b,
			input logic [9:0] c);
		logic [9:0] m;
		if (a <= b && a <= c) begin
			m = (b <= c) ? b : c;
		end else if (b <= a && b <= c) begin
			m = (a <= c) ? a : c;
		end else begin
			m = (a <= b) ? a : b;
		end
		return m;
	endfunction

	// Logical channel to analogue mux code
	function automatic logic [3:0] code_of(input logic [3:0] ch);
		logic [3:0] code;
		if (ch < 4'd4) begin
			code = ch;
		end else if (ch < 4'd6) begin
			code = ch + 4'd2;
		end else begin
			code = MUX_BANDGAP;
		end
		return code;
	endfunction

endpackage

[rtl/asm_chan_if.sv]
// Valid/ready channel interfaces for command beats and result beats.
// Depends on asm_pkg for the payload types.
interface asm_cmd_if;
	import asm_pkg::*;
	logic valid;
	logic ready;
	cmd_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface asm_res_if;
	import asm_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/asm_core.sv]
// Scan sequencer state and single-step rule: computes the result of one command
// beat and updates the state when the beat is accepted. Depends on asm_pkg.
module asm_core import asm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  cmd_t cmd_data,
	output res_t res_data
);

	logic [2:0]  phase_q;
	logic [3:0]  channel_q;
	logic [5:0]  repeat_q;
	logic [9:0]  first_q;
	logic [9:0]  second_q;
	logic [15:0] sum_q;
	logic [3:0]  mux_q;

	logic [2:0]  phase_d;
	logic [3:0]  channel_d;
	logic [5:0]  repeat_d;
	logic [9:0]  first_d;
	logic [9:0]  second_d;
	logic [15:0] sum_d;
	logic [3:0]  mux_d;
	logic        conv;
	logic        done;
	logic [15:0] sum_add;
	logic [5:0]  repeat_inc;
	logic [3:0]  channel_inc;

	assign sum_add     = sum_q + {6'd0, med3(first_q, second_q, cmd_data.sample)};
	assign repeat_inc  = repeat_q + 6'd1;
	assign channel_inc = channel_q + 4'd1;

	// Next state for one command beat
	always_comb begin
		phase_d   = phase_q;
		channel_d = channel_q;
		repeat_d  = repeat_q;
		first_d   = first_q;
		second_d  = second_q;
		sum_d     = sum_q;
		mux_d     = mux_q;
		conv      = 1'b0;
		done      = 1'b0;
		case (cmd_data.command)
			CMD_START: begin
				phase_d = PH_START;
			end
			CMD_STOP: begin
				phase_d = PH_IDLE;
			end
			CMD_CONV: begin
				if (phase_q == PH_S1) begin
					first_d = cmd_data.sample;
					conv    = 1'b1;
					phase_d = PH_S2;
				end else if (phase_q == PH_S2) begin
					second_d = cmd_data.sample;
					conv     = 1'b1;
					phase_d  = PH_S3;
				end else if (phase_q == PH_S3) begin
					sum_d = sum_add;
					if (repeat_inc >= SamplesPerChannel) begin
						repeat_d = 6'd0;
						done     = 1'b1;
						if (channel_inc >= Channels) begin
							channel_d = 4'd0;
							phase_d   = PH_DONE;
						end else begin
							channel_d = channel_inc;
							mux_d     = MUX_GROUND;
							phase_d   = PH_GROUND;
						end
					end else begin
						repeat_d = repeat_inc;
						conv     = 1'b1;
						phase_d  = PH_S1;
					end
				end
			end
			default: begin
				// poll
				if (phase_q == PH_START) begin
					channel_d = 4'd0;
					repeat_d  = 6'd0;
					mux_d     = 4'd0;
					sum_d     = 16'd0;
					phase_d   = PH_S1;
					conv      = 1'b1;
				end else if (phase_q == PH_GROUND || phase_q == PH_NEXT) begin
					mux_d   = code_of(channel_q);
					sum_d   = 16'd0;
					phase_d = PH_S1;
					conv    = 1'b1;
				end
			end
		endcase
	end

	// Result fields show the state after the step
	always_comb begin
		res_data.phase            = phase_d;
		res_data.mux_code         = mux_d;
		res_data.start_conversion = conv;
		res_data.sum_valid        = done;
		res_data.sum_channel      = done ? channel_q : 4'd0;
		res_data.sum_value        = done ? sum_add : 16'd0;
	end

	// Advance state on an accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			channel_q <= 4'd0;
			repeat_q  <= 6'd0;
			first_q   <= 10'd0;
			second_q  <= 10'd0;
			sum_q     <= 16'd0;
			mux_q     <= 4'd0;
		end else if (accept) begin
			phase_q   <= phase_d;
			channel_q <= channel_d;
			repeat_q  <= repeat_d;
			first_q   <= first_d;
			second_q  <= second_d;
			sum_q     <= sum_d;
			mux_q     <= mux_d;
		end
	end

endmodule

[rtl/asm_out_buf.sv]
// Output register with a skid stage: holds result beats while the receiver
// stalls so that the command side keeps moving. Depends on asm_pkg.
module asm_out_buf import asm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	output logic space,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_data
);

	logic valid_q;
	logic skid_valid_q;
	res_t data_q;
	res_t skid_q;
	logic drain;

	assign space     = !skid_valid_q;
	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign drain     = !valid_q || out_ready;

	// Track occupancy of output and skid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (drain) begin
			if (skid_valid_q) begin
				valid_q      <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Move payloads
	always_ff @(posedge clk) begin
		if (drain) begin
			data_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

[rtl/adc_scan_median_accumulator_unit.sv]
// ADC scan median accumulator top level: command channel in, result channel out.
// Depends on asm_pkg, asm_chan_if, asm_core and asm_out_buf.
//
// Usage:
//   cmd carries one command beat (command, sample): start, stop, conversion
//   done with a 10-bit sample, or poll. Every accepted command beat yields
//   exactly one result beat on res: phase, mux_code, start_conversion and,
//   when a channel has finished its repeats, sum_valid with the channel index
//   and its 16-bit wrapping sum of medians.
//   An accepted beat's result is registered in the output register or, while
//   res stalls, in the skid stage. Throughput: one beat per cycle while the
//   skid is empty; the step rule sits between the state and output registers.
//   Stall: when res is not taken, the output register holds its beat and a
//   one-entry skid stage takes the next one; cmd.ready drops only while the
//   skid stage is occupied, and rises again as soon as res drains.
//   Reset: arst_n clears the sequencer to idle with channel, repeat count,
//   samples, sum and mux code at zero, and empties both output stages.
module adc_scan_median_accumulator_unit import asm_pkg::*; (
	input logic clk,
	input logic arst_n,
	asm_cmd_if.sink cmd,
	asm_res_if.source res
);

	logic accept;
	logic space;
	res_t step_res;

	assign cmd.ready = space;
	assign accept    = cmd.valid && space;

	// Step rule and sequencer state
	asm_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.cmd_data (cmd.data),
		.res_data (step_res)
	);

	// Result register and skid stage
	asm_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (step_res),
		.space     (space),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.out_data  (res.data)
	);

endmodule

[rtl/asm_checker.sv]
// Port-level checks for the ADC scan median accumulator, with the bind that
// attaches them to the top level. Depends on asm_pkg.
module asm_checker import asm_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [2:0]  phase,
	input logic        start_conversion,
	input logic        sum_valid,
	input logic [3:0]  sum_channel,
	input logic [15:0] sum_value
);

	// Hold a stalled result beat
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped while stalled");

	// Finished sum only on the step that leaves for ground or complete
	a_sum_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && sum_valid |-> (phase == PH_GROUND || phase == PH_DONE))
		else $error("finished sum outside ground or complete phase");

	// Sum fields zero without a finished sum
	a_sum_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !sum_valid |-> (sum_channel == 4'd0 && sum_value == 16'd0))
		else $error("sum fields not cleared");

	// Conversion request lands in a sampling phase
	a_conv_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && start_conversion |->
			(phase == PH_S1 || phase == PH_S2 || phase == PH_S3))
		else $error("conversion requested outside sampling");

	// Finished channel index stays within the scan
	a_sum_chan: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && sum_valid |-> sum_channel < Channels)
		else $error("finished channel index out of range");

endmodule

bind adc_scan_median_accumulator_unit asm_checker u_asm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.phase            (res.data.phase),
	.start_conversion (res.data.start_conversion),
	.sum_valid        (res.data.sum_valid),
	.sum_channel      (res.data.sum_channel),
	.sum_value        (res.data.sum_value)
);
